// ===== hdl/pgu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgu_pkg
// shared types, constants and helpers of the particle update pipeline
// ----------------------------------------------------------------------------
package pgu_pkg;

    typedef enum logic [1:0] {
        ST_INACTIVE = 2'd0,
        ST_EXPIRED  = 2'd1,
        ST_ALIVE    = 2'd2
    } status_t;

    localparam logic [1:0] CFG_CAMERA_X = 2'd0;
    localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
    localparam logic [1:0] CFG_CAMERA_Z = 2'd2;

    // 4.905 in Q16.16
    localparam logic [18:0] HALF_GRAVITY = 19'd321454;
    localparam logic [7:0]  COLOR_FADE   = 8'd10;

    localparam int SQRT_STAGES = 8;
    localparam int SQRT_STEPS  = 4;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] life;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [7:0]         green;
        logic [7:0]         blue;
    } rec_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -35'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [7:0] fade(input logic [7:0] c);
        return (c < COLOR_FADE) ? 8'd0 : c - COLOR_FADE;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pgu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgu channel interfaces
// request carries one particle record, response carries the updated record
// ----------------------------------------------------------------------------
interface pgu_req_if;
    logic               valid;
    logic               ready;
    logic [15:0]        step_time;
    logic signed [31:0] life_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] pos_z_in;
    logic signed [31:0] vel_x_in;
    logic signed [31:0] vel_y_in;
    logic signed [31:0] vel_z_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;

    modport source (output valid, step_time, life_in, pos_x_in, pos_y_in, pos_z_in,
                    vel_x_in, vel_y_in, vel_z_in, green_in, blue_in, input ready);
    modport sink   (input valid, step_time, life_in, pos_x_in, pos_y_in, pos_z_in,
                    vel_x_in, vel_y_in, vel_z_in, green_in, blue_in, output ready);
endinterface

interface pgu_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] life_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] pos_z_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic signed [31:0] vel_z_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [31:0]        camera_distance;

    modport source (output valid, status, life_out, pos_x_out, pos_y_out, pos_z_out,
                    vel_x_out, vel_y_out, vel_z_out, green_out, blue_out,
                    camera_distance, input ready);
    modport sink   (input valid, status, life_out, pos_x_out, pos_y_out, pos_z_out,
                    vel_x_out, vel_y_out, vel_z_out, green_out, blue_out,
                    camera_distance, output ready);
endinterface
`default_nettype wire

// ===== hdl/particle_gravity_update_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_gravity_update_step
// one Euler step with gravity per particle record, distance to the camera
// ----------------------------------------------------------------------------
// usage:
//   req carries one particle record and the frame step, rsp returns the
//   updated record, one response per request, in order.
//   the camera position is written through cfg_wen / cfg_index / cfg_wdata
//   while no transaction is in flight; index 3 is ignored.
// stages: six arithmetic stages (life and gravity, velocity products, position,
//   differences, squares, sum) followed by an eight stage square root.
// throughput: one record per cycle; the whole pipeline advances whenever
//   the output register is empty or its transaction completes.
// reset: all valid bits clear, the camera position returns to the origin.
// stall: when rsp.ready is low with a result waiting, the whole pipeline
//   holds, bubbles included, and req.ready drops.
// ----------------------------------------------------------------------------
module particle_gravity_update_step (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pgu_req_if.sink          req,
    pgu_rsp_if.source        rsp,
    input  wire logic        cfg_wen,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    localparam int N_ST = 6 + pgu_pkg::SQRT_STAGES;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;

    logic               vld_reg [N_ST];
    pgu_pkg::rec_t      rec_reg [N_ST];
    pgu_pkg::rec_t      rec_next[N_ST];
    logic [15:0]        dt1_reg;
    logic signed [48:0] p2_x_reg, p2_y_reg, p2_z_reg;
    logic [31:0]        a4_x_reg, a4_y_reg, a4_z_reg;
    logic [63:0]        q5_x_reg, q5_y_reg, q5_z_reg;
    logic [63:0]        sum6_reg;
    logic               sat_reg [pgu_pkg::SQRT_STAGES+1];
    logic               en;
    logic [31:0]        root;

    assign en        = !vld_reg[N_ST-1] || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                pgu_pkg::CFG_CAMERA_X: cam_x_reg <= cfg_wdata;
                pgu_pkg::CFG_CAMERA_Y: cam_y_reg <= cfg_wdata;
                pgu_pkg::CFG_CAMERA_Z: cam_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: life and gravity
    logic               alive0;
    logic signed [31:0] life_sub;
    logic [35:0]        dv_full;
    logic [19:0]        dv;
    pgu_pkg::rec_t      r0;

    always_comb
    begin
        alive0   = req.life_in > 32'sd0;
        life_sub = req.life_in - $signed({16'd0, req.step_time});
        dv_full  = 36'(pgu_pkg::HALF_GRAVITY * req.step_time) + 36'd32768;
        dv       = dv_full[35:16];
        r0.life  = req.life_in;
        r0.pos_x = req.pos_x_in;
        r0.pos_y = req.pos_y_in;
        r0.pos_z = req.pos_z_in;
        r0.vel_x = req.vel_x_in;
        r0.vel_y = req.vel_y_in;
        r0.vel_z = req.vel_z_in;
        r0.green = req.green_in;
        r0.blue  = req.blue_in;
        r0.status = pgu_pkg::ST_INACTIVE;
        if (alive0)
        begin
            r0.life = life_sub;
            if (life_sub <= 32'sd0)
                r0.status = pgu_pkg::ST_EXPIRED;
            else
            begin
                r0.status = pgu_pkg::ST_ALIVE;
                r0.vel_y  = pgu_pkg::sat32({{3{req.vel_y_in[31]}}, req.vel_y_in}
                                           - $signed({15'd0, dv}));
            end
        end
    end

    // stage 3: position update and color fade
    logic signed [49:0] t_x, t_y, t_z;
    pgu_pkg::rec_t      r2;

    always_comb
    begin
        t_x = {p2_x_reg[48], p2_x_reg} + 50'sd32768;
        t_y = {p2_y_reg[48], p2_y_reg} + 50'sd32768;
        t_z = {p2_z_reg[48], p2_z_reg} + 50'sd32768;
        r2  = rec_reg[1];
        if (rec_reg[1].status == pgu_pkg::ST_ALIVE)
        begin
            r2.pos_x = pgu_pkg::sat32({{3{rec_reg[1].pos_x[31]}}, rec_reg[1].pos_x}
                                      + {t_x[49], t_x[49:16]});
            r2.pos_y = pgu_pkg::sat32({{3{rec_reg[1].pos_y[31]}}, rec_reg[1].pos_y}
                                      + {t_y[49], t_y[49:16]});
            r2.pos_z = pgu_pkg::sat32({{3{rec_reg[1].pos_z[31]}}, rec_reg[1].pos_z}
                                      + {t_z[49], t_z[49:16]});
            r2.green = pgu_pkg::fade(rec_reg[1].green);
            r2.blue  = pgu_pkg::fade(rec_reg[1].blue);
        end
    end

    // stage 4: absolute differences to the camera
    logic signed [32:0] d_x, d_y, d_z;
    logic [32:0]        m_x, m_y, m_z;

    always_comb
    begin
        d_x = {rec_reg[2].pos_x[31], rec_reg[2].pos_x} - {cam_x_reg[31], cam_x_reg};
        d_y = {rec_reg[2].pos_y[31], rec_reg[2].pos_y} - {cam_y_reg[31], cam_y_reg};
        d_z = {rec_reg[2].pos_z[31], rec_reg[2].pos_z} - {cam_z_reg[31], cam_z_reg};
        m_x = d_x[32] ? 33'(-d_x) : d_x;
        m_y = d_y[32] ? 33'(-d_y) : d_y;
        m_z = d_z[32] ? 33'(-d_z) : d_z;
    end

    logic [65:0] sum_full;
    assign sum_full = {2'b00, q5_x_reg} + {2'b00, q5_y_reg} + {2'b00, q5_z_reg};

    always_comb
    begin
        rec_next[0] = r0;
        rec_next[1] = rec_reg[0];
        rec_next[2] = r2;
        for (int i = 3; i < N_ST; i++)
            rec_next[i] = rec_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < N_ST; i++)
                vld_reg[i] <= 1'b0;
        else if (en)
        begin
            vld_reg[0] <= req.valid;
            for (int i = 1; i < N_ST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N_ST; i++)
                rec_reg[i] <= rec_next[i];
            dt1_reg  <= req.step_time;
            p2_x_reg <= $signed(rec_reg[0].vel_x) * $signed({1'b0, dt1_reg});
            p2_y_reg <= $signed(rec_reg[0].vel_y) * $signed({1'b0, dt1_reg});
            p2_z_reg <= $signed(rec_reg[0].vel_z) * $signed({1'b0, dt1_reg});
            a4_x_reg <= m_x[31:0];
            a4_y_reg <= m_y[31:0];
            a4_z_reg <= m_z[31:0];
            q5_x_reg <= a4_x_reg * a4_x_reg;
            q5_y_reg <= a4_y_reg * a4_y_reg;
            q5_z_reg <= a4_z_reg * a4_z_reg;
            sum6_reg <= sum_full[63:0];
            sat_reg[0] <= sum_full[65:64] != 2'b00;
            for (int i = 1; i <= pgu_pkg::SQRT_STAGES; i++)
                sat_reg[i] <= sat_reg[i-1];
        end
    end

    pgu_isqrt u_isqrt (
        .clk   (clk),
        .en    (en),
        .x     (sum6_reg),
        .root  (root)
    );

    assign rsp.valid     = vld_reg[N_ST-1];
    assign rsp.status    = rec_reg[N_ST-1].status;
    assign rsp.life_out  = rec_reg[N_ST-1].life;
    assign rsp.pos_x_out = rec_reg[N_ST-1].pos_x;
    assign rsp.pos_y_out = rec_reg[N_ST-1].pos_y;
    assign rsp.pos_z_out = rec_reg[N_ST-1].pos_z;
    assign rsp.vel_x_out = rec_reg[N_ST-1].vel_x;
    assign rsp.vel_y_out = rec_reg[N_ST-1].vel_y;
    assign rsp.vel_z_out = rec_reg[N_ST-1].vel_z;
    assign rsp.green_out = rec_reg[N_ST-1].green;
    assign rsp.blue_out  = rec_reg[N_ST-1].blue;
    assign rsp.camera_distance =
        (rec_reg[N_ST-1].status != pgu_pkg::ST_ALIVE) ? 32'd0 :
        (sat_reg[pgu_pkg::SQRT_STAGES] ? 32'hFFFFFFFF : root);

`ifndef SYNTHESIS
    a_ready_follows_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
        else $error("input ready does not follow the output stall");

    a_dist_only_alive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.camera_distance != 32'd0 |-> rsp.status == pgu_pkg::ST_ALIVE)
        else $error("camera distance on a particle that is not alive");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.camera_distance))
        else $error("waiting result changed during a stall");
`endif

endmodule
`default_nettype wire

// ===== hdl/pgu_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pgu_isqrt
// pipelined truncating square root of a 64 bit value, four result bits a stage
// ----------------------------------------------------------------------------
module pgu_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output logic      [31:0] root
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] xs;
    } sq_t;

    sq_t stage_reg  [pgu_pkg::SQRT_STAGES];
    sq_t stage_next [pgu_pkg::SQRT_STAGES];

    function automatic sq_t steps(input sq_t s);
        sq_t         o;
        logic [35:0] r;
        logic [35:0] t;
        o = s;
        for (int k = 0; k < pgu_pkg::SQRT_STEPS; k++)
        begin
            r = {o.rem, o.xs[63:62]};
            t = {2'b00, o.root, 2'b01};
            if (r >= t)
            begin
                o.rem  = 34'(r - t);
                o.root = {o.root[30:0], 1'b1};
            end
            else
            begin
                o.rem  = r[33:0];
                o.root = {o.root[30:0], 1'b0};
            end
            o.xs = {o.xs[61:0], 2'b00};
        end
        return o;
    endfunction

    always_comb
    begin
        sq_t s0;
        s0.rem  = '0;
        s0.root = '0;
        s0.xs   = x;
        stage_next[0] = steps(s0);
        for (int i = 1; i < pgu_pkg::SQRT_STAGES; i++)
            stage_next[i] = steps(stage_reg[i-1]);
    end

    // payload only, reset not needed
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < pgu_pkg::SQRT_STAGES; i++)
                stage_reg[i] <= stage_next[i];
    end

    assign root = stage_reg[pgu_pkg::SQRT_STAGES-1].root;

endmodule
`default_nettype wire
